@@ rtl/tkfs_pkg.sv @@
`default_nettype none
package tkfs_pkg;

  // Results per batch never exceed this many, whatever the list depth.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned FLOW_W      = 32;

  // Commands from the controller to the sorted-list datapath.
  typedef struct packed {
    logic insert;  // insert the incoming candidate into the list
    logic shift;   // move every entry one place toward the head
    logic clear;   // drop all entries
  } tkfs_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] filled_sat;  // entry count, saturated at MAX_RESULTS
  } tkfs_status_t;

endpackage
`default_nettype wire

@@ rtl/tkfs_datapath.sv @@
`default_nettype none
module tkfs_datapath
  import tkfs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tkfs_cmd_t         cmd,
  input  wire logic [ID_W-1:0]   in_id,
  input  wire logic [FLOW_W-1:0] in_flow,
  output tkfs_status_t           status,
  output logic [ID_W-1:0]        head_id,
  output logic [FLOW_W-1:0]      head_flow
);

  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic [ID_W-1:0]   entry_id   [DEPTH];
  logic [FLOW_W-1:0] entry_flow [DEPTH];
  logic [DEPTH-1:0]  entry_valid;
  logic [FW-1:0]     filled_count;
  logic [DEPTH-1:0]  ranks_ahead;

  // An entry stays in place when it ranks ahead of the new item; held entries
  // win ties, so the earlier item comes first.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ranks_ahead[i] = entry_valid[i] && (entry_flow[i] >= in_flow);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic take_new;
      logic take_prev;
      logic [ID_W-1:0]   prev_id;
      logic [FLOW_W-1:0] prev_flow;
      logic              prev_valid;
      logic [ID_W-1:0]   nxt_id;
      logic [FLOW_W-1:0] nxt_flow;

      if (g == 0) begin : g_head
        assign take_new   = !ranks_ahead[g];
        assign take_prev  = 1'b0;
        assign prev_id    = in_id;
        assign prev_flow  = in_flow;
        assign prev_valid = 1'b1;
      end else begin : g_body
        assign take_new   = !ranks_ahead[g] && ranks_ahead[g-1];
        assign take_prev  = !ranks_ahead[g] && !ranks_ahead[g-1];
        assign prev_id    = entry_id[g-1];
        assign prev_flow  = entry_flow[g-1];
        assign prev_valid = entry_valid[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign nxt_id   = entry_id[g];
        assign nxt_flow = entry_flow[g];
      end else begin : g_inner
        assign nxt_id   = entry_id[g+1];
        assign nxt_flow = entry_flow[g+1];
      end

      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (take_new) begin
            entry_id[g]   <= in_id;
            entry_flow[g] <= in_flow;
          end else if (take_prev) begin
            entry_id[g]   <= prev_id;
            entry_flow[g] <= prev_flow;
          end
        end else if (cmd.shift) begin
          entry_id[g]   <= nxt_id;
          entry_flow[g] <= nxt_flow;
        end
      end

      always_ff @(posedge clk) begin
        if (rst || cmd.clear) begin
          entry_valid[g] <= 1'b0;
        end else if (cmd.insert) begin
          if (take_new) begin
            entry_valid[g] <= 1'b1;
          end else if (take_prev) begin
            entry_valid[g] <= prev_valid;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      filled_count <= '0;
    end else if (cmd.insert && !ranks_ahead[DEPTH-1] &&
                 (32'(filled_count) < DEPTH)) begin
      filled_count <= filled_count + FW'(1);
    end
  end

  always_comb begin
    if (32'(filled_count) > MAX_RESULTS) begin
      status.filled_sat = CNT_W'(MAX_RESULTS);
    end else begin
      status.filled_sat = CNT_W'(filled_count);
    end
  end

  assign head_id   = entry_id[0];
  assign head_flow = entry_flow[0];

endmodule
`default_nettype wire

@@ rtl/tkfs_ctrl.sv @@
`default_nettype none
module tkfs_ctrl
  import tkfs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_present,
  input  wire logic             in_last,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_nonempty,
  output logic                  out_last,
  input  wire logic             cfg_valid,
  input  wire logic [CNT_W-1:0] cfg_data,
  output logic                  cfg_ready,
  output tkfs_cmd_t             cmd,
  input  wire tkfs_status_t     status
);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_SIZE    = 2'd1;
  localparam logic [1:0] ST_EMIT    = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] max_count;
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] batch_size;
  logic             empty;
  logic             in_xfer;
  logic             out_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= CNT_W'(MAX_RESULTS);
    end else if (cfg_valid) begin
      max_count <= cfg_data;
    end
  end

  assign limit      = (32'(max_count) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : max_count;
  assign batch_size = (status.filled_sat < limit) ? status.filled_sat : limit;

  assign in_ready     = (state == ST_COLLECT);
  assign in_xfer      = in_valid && in_ready;
  assign out_valid    = (state == ST_EMIT);
  assign out_xfer     = out_valid && out_ready;
  assign out_nonempty = !empty;
  assign out_last     = empty || (remaining == CNT_W'(1));

  always_comb begin
    cmd.insert = in_xfer && in_present;
    cmd.shift  = out_xfer && !out_last;
    cmd.clear  = out_xfer && out_last;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (in_xfer && in_last) begin
          state_next = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && out_last) begin
          state_next = ST_COLLECT;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      empty     <= 1'b0;
    end else if (state == ST_SIZE) begin
      remaining <= batch_size;
      empty     <= (batch_size == '0);
    end else if (cmd.shift) begin
      remaining <= remaining - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/top_k_by_flow_selector.sv @@
`default_nettype none
// The first result of a batch is offered after the sizing state (ST_SIZE) that
// follows the transfer carrying the last candidate; results then leave one per
// cycle while m_tready is high. One candidate is taken per cycle while a batch is
// collected; s_tready then stays low through the sizing state and until the last
// result is taken, an empty batch counting as one result.
// Reset (rst, synchronous, active high) empties the list and sets max_count to 16.
module top_k_by_flow_selector
  import tkfs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Candidate input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] landmark_id, [63:32] flow
  input  wire logic        s_tuser,   // [0] flow_present
  input  wire logic        s_tlast,   // last_item
  // Selected landmark output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] landmark_id_res, [63:32] flow_res
  output logic             m_tuser,   // [0] valid_res
  output logic             m_tlast,   // last_result
  // Configuration write channel for max_count.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);

  // The datapath is a shift-insert chain of DEPTH entries kept sorted by
  // descending flow. Each entry compares its flow against the incoming
  // candidate in parallel, so a transfer is absorbed as it is accepted.
  // During output the chain shifts toward its head, so the head entry is
  // always the next result to send.

  tkfs_cmd_t         cmd;
  tkfs_status_t      status;
  logic [ID_W-1:0]   head_id;
  logic [FLOW_W-1:0] head_flow;
  logic              out_nonempty;

  tkfs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_present   (s_tuser),
    .in_last      (s_tlast),
    .in_ready     (s_tready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_nonempty (out_nonempty),
    .out_last     (m_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cfg_ready    (cfg_ready),
    .cmd          (cmd),
    .status       (status)
  );

  tkfs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_id     (s_tdata[31:0]),
    .in_flow   (s_tdata[63:32]),
    .status    (status),
    .head_id   (head_id),
    .head_flow (head_flow)
  );

  // An empty batch sends a single transfer with zero id and flow, marked
  // invalid and last.
  always_comb begin
    if (out_nonempty) begin
      m_tdata = {head_flow, head_id};
    end else begin
      m_tdata = '0;
    end
  end

  assign m_tuser = out_nonempty;

endmodule
`default_nettype wire
